### hw/rtl/mfb_pkg.sv
// Package for the monochrome frame buffer with row scanout.
// Holds the operation, result and command codes and the controller/datapath structs.
// Depends on nothing.
package mfb_pkg;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_TOGGLE = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_ROW    = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [7:0] CMD_ROW_LO    = 8'h20;
    localparam logic [7:0] CMD_ROW_HI    = 8'h30;
    localparam logic [7:0] CMD_COL_RESET = 8'h00;
    localparam logic [7:0] PIX_MSB_MASK  = 8'h80;

    typedef logic [2:0] t_asel;
    localparam t_asel ASEL_IN    = 3'd0;
    localparam t_asel ASEL_PIX   = 3'd1;
    localparam t_asel ASEL_ROW0  = 3'd2;
    localparam t_asel ASEL_ROWNX = 3'd3;
    localparam t_asel ASEL_CLR   = 3'd4;

    typedef logic [2:0] t_osel;
    localparam t_osel OSEL_ZERO = 3'd0;
    localparam t_osel OSEL_PIX  = 3'd1;
    localparam t_osel OSEL_CMD0 = 3'd2;
    localparam t_osel OSEL_CMD1 = 3'd3;
    localparam t_osel OSEL_CMD2 = 3'd4;
    localparam t_osel OSEL_DATA = 3'd5;

    typedef struct packed {
        logic  latch;
        logic  rd_en;
        logic  wr_en;
        t_asel asel;
        logic  out_load;
        t_osel osel;
        logic  col_clr;
        logic  col_inc;
        logic  clr_inc;
    } t_cmd;

    typedef struct packed {
        logic pix_ok;
        logic row_ok;
        logic col_last;
        logic clr_done;
    } t_sts;

endpackage

### hw/rtl/mfb_if.sv
// Handshake interfaces for the frame buffer: operation words in, result words out.
// Uses no package; widths are fixed by the word formats.
interface mfb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] x_coord;
    logic [7:0] y_coord;

    modport source(output valid, output mode, output x_coord, output y_coord, input ready);
    modport sink(input valid, input mode, input x_coord, input y_coord, output ready);
endinterface

interface mfb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       pixel_value;
    logic       in_range;
    logic       last;

    modport source(output valid, output kind, output byte_out, output pixel_value,
                   output in_range, output last, input ready);
    modport sink(input valid, input kind, input byte_out, input pixel_value,
                 input in_range, input last, output ready);
endinterface

### hw/rtl/mfb_ctrl.sv
// Controller state machine of the frame buffer: clearing sweep, pixel update and row scanout.
// Depends on mfb_pkg; drives the datapath through t_cmd and reads t_sts.
module mfb_ctrl
    import mfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PIX   = 3'd2;
    localparam logic [2:0] S_STAT  = 3'd3;
    localparam logic [2:0] S_CMD0  = 3'd4;
    localparam logic [2:0] S_CMD1  = 3'd5;
    localparam logic [2:0] S_CMD2  = 3'd6;
    localparam logic [2:0] S_DATA  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.asel    = ASEL_CLR;
                o_cmd.clr_inc = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.asel = ASEL_IN;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    o_cmd.rd_en = i_sts.pix_ok;
                    if (i_sts.pix_ok) begin
                        n_state = S_PIX;
                    end else if (i_sts.row_ok) begin
                        n_state = S_CMD0;
                    end else begin
                        n_state = S_STAT;
                    end
                end
            end
            S_PIX: begin
                o_cmd.asel = ASEL_PIX;
                o_cmd.osel = OSEL_PIX;
                if (out_free) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_STAT: begin
                o_cmd.osel = OSEL_ZERO;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CMD0: begin
                o_cmd.osel = OSEL_CMD0;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_CMD1;
                end
            end
            S_CMD1: begin
                o_cmd.osel = OSEL_CMD1;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_CMD2;
                end
            end
            S_CMD2: begin
                o_cmd.osel = OSEL_CMD2;
                o_cmd.asel = ASEL_ROW0;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.col_clr  = 1'b1;
                    n_state        = S_DATA;
                end
            end
            S_DATA: begin
                o_cmd.osel = OSEL_DATA;
                o_cmd.asel = ASEL_ROWNX;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.col_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.col_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_rd_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("memory read and write issued in the same cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.out_load)
        else $error("result register overwritten while its word waits");

    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_sts.row_ok && !i_sts.pix_ok)
        |=> (r_state == S_CMD0))
        else $error("row refresh did not start with the command bytes");

    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA && o_cmd.out_load && i_sts.col_last) |=> (r_state == S_IDLE))
        else $error("row scanout did not end after its last data byte");

endmodule

### hw/rtl/mfb_dpath.sv
// Datapath of the frame buffer: frame memory, address generation, pixel update, result register.
// Depends on mfb_pkg; controlled through t_cmd, reports through t_sts.
module mfb_dpath
    import mfb_pkg::*;
#(
    parameter int WIDTH_PIXELS = 128,
    parameter int HEIGHT_ROWS  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_x_coord,
    input  logic [7:0] i_y_coord,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte_out,
    output logic       o_pixel_value,
    output logic       o_in_range,
    output logic       o_last
);

    localparam int ROW_BYTES   = WIDTH_PIXELS / 8;
    localparam int STORE_BYTES = ROW_BYTES * HEIGHT_ROWS;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int COL_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int IDX_W       = 8 + $clog2(ROW_BYTES + 1) + 1;

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    logic [2:0]        r_mode;
    logic [2:0]        r_bit;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_row_base;
    logic [7:0]        r_y;
    logic [COL_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic       r_pix;
    logic       r_rng;
    logic       r_last;

    logic [IDX_W-1:0]  row_prod;
    logic [IDX_W-1:0]  pix_idx;
    logic              x_ok;
    logic              y_ok;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mask;
    logic [7:0]        cur;
    logic [7:0]        wdata;

    assign row_prod = IDX_W'(i_y_coord) * IDX_W'(ROW_BYTES);
    assign pix_idx  = row_prod + IDX_W'(i_x_coord[7:3]);
    assign x_ok     = {1'b0, i_x_coord} < 9'(WIDTH_PIXELS);
    assign y_ok     = {1'b0, i_y_coord} < 9'(HEIGHT_ROWS);

    assign o_sts.pix_ok   = (i_mode <= MODE_READ) && x_ok && y_ok
                            && (pix_idx < IDX_W'(STORE_BYTES));
    assign o_sts.row_ok   = (i_mode == MODE_ROW) && y_ok;
    assign o_sts.col_last = (r_col == COL_W'(ROW_BYTES - 1));
    assign o_sts.clr_done = (r_clr_addr == ADDR_W'(STORE_BYTES - 1));

    always_comb begin
        case (i_cmd.asel)
            ASEL_IN:    mem_addr = pix_idx[ADDR_W-1:0];
            ASEL_PIX:   mem_addr = r_idx;
            ASEL_ROW0:  mem_addr = r_row_base;
            ASEL_ROWNX: mem_addr = r_row_base + ADDR_W'(r_col) + ADDR_W'(1);
            ASEL_CLR:   mem_addr = r_clr_addr;
            default:    mem_addr = r_idx;
        endcase
    end

    assign mask = PIX_MSB_MASK >> r_bit;

    always_comb begin
        case (r_mode)
            MODE_CLEAR:  cur = r_rdata & ~mask;
            MODE_SET:    cur = r_rdata | mask;
            MODE_TOGGLE: cur = r_rdata ^ mask;
            default:     cur = r_rdata;
        endcase
    end

    assign wdata = (i_cmd.asel == ASEL_CLR) ? 8'h00 : cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[mem_addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode     <= i_mode;
            r_bit      <= i_x_coord[2:0];
            r_idx      <= pix_idx[ADDR_W-1:0];
            r_row_base <= row_prod[ADDR_W-1:0];
            r_y        <= i_y_coord;
        end
        if (i_cmd.col_clr) begin
            r_col <= '0;
        end else if (i_cmd.col_inc) begin
            r_col <= r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_inc) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.osel)
                OSEL_PIX: begin
                    r_kind <= KIND_STATUS;
                    r_byte <= cur;
                    r_pix  <= |(cur & mask);
                    r_rng  <= 1'b1;
                    r_last <= 1'b1;
                end
                OSEL_CMD0: begin
                    r_kind <= KIND_CMD;
                    r_byte <= CMD_ROW_LO | {4'h0, r_y[3:0]};
                    r_pix  <= 1'b0;
                    r_rng  <= 1'b1;
                    r_last <= 1'b0;
                end
                OSEL_CMD1: begin
                    r_kind <= KIND_CMD;
                    r_byte <= CMD_ROW_HI | {4'h0, r_y[7:4]};
                    r_pix  <= 1'b0;
                    r_rng  <= 1'b1;
                    r_last <= 1'b0;
                end
                OSEL_CMD2: begin
                    r_kind <= KIND_CMD;
                    r_byte <= CMD_COL_RESET;
                    r_pix  <= 1'b0;
                    r_rng  <= 1'b1;
                    r_last <= 1'b0;
                end
                OSEL_DATA: begin
                    r_kind <= KIND_DATA;
                    r_byte <= r_rdata;
                    r_pix  <= 1'b0;
                    r_rng  <= 1'b1;
                    r_last <= o_sts.col_last;
                end
                default: begin
                    r_kind <= KIND_STATUS;
                    r_byte <= 8'h00;
                    r_pix  <= 1'b0;
                    r_rng  <= 1'b0;
                    r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_kind        = r_kind;
    assign o_byte_out    = r_byte;
    assign o_pixel_value = r_pix;
    assign o_in_range    = r_rng;
    assign o_last        = r_last;

endmodule

### hw/rtl/mono_framebuffer_pixel_scanout_top.sv
// Top level of the monochrome 1 bpp frame buffer with pixel access and row scanout.
// Depends on mfb_pkg, mfb_if, mfb_ctrl and mfb_dpath.
//
//  Port    Direction  Word
//  i_pix   in         mode, x_coord, y_coord
//  o_res   out        kind, byte_out, pixel_value, in_range, last
//
// After reset the frame memory is swept to zero, one byte a cycle, before the first
// word is taken. A pixel operation is a single-port memory read in the accepting
// cycle followed by the write; a rejected word is answered with one status word.
// A row refresh is the accepting cycle followed by three command bytes and
// WIDTH_PIXELS/8 data bytes (16 by default). A stalled output holds the
// controller in place; a new word is accepted while the previous result still waits.
module mono_framebuffer_pixel_scanout_top
    import mfb_pkg::*;
#(
    parameter int WIDTH_PIXELS = 128,
    parameter int HEIGHT_ROWS  = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mfb_in_if.sink          i_pix,
    mfb_out_if.source       o_res
);

    t_cmd cmd;
    t_sts sts;

    mfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mfb_dpath #(
        .WIDTH_PIXELS (WIDTH_PIXELS),
        .HEIGHT_ROWS  (HEIGHT_ROWS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_pix.mode),
        .i_x_coord     (i_pix.x_coord),
        .i_y_coord     (i_pix.y_coord),
        .o_kind        (o_res.kind),
        .o_byte_out    (o_res.byte_out),
        .o_pixel_value (o_res.pixel_value),
        .o_in_range    (o_res.in_range),
        .o_last        (o_res.last)
    );

endmodule

### bench/mfb_scanout_checker.sv
// Checker for the monochrome frame buffer: watches the operation and result channels,
// keeps its own copy of the frame store and compares every result word in order.
// Depends on mfb_pkg and the handshake interfaces in mfb_if.
module mfb_scanout_checker
    import mfb_pkg::*;
#(
    parameter int WIDTH_PIXELS = 128,
    parameter int HEIGHT_ROWS  = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mfb_in_if    i_pix,
    mfb_out_if   i_res,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_BYTES   = WIDTH_PIXELS / 8;
    localparam int STORE_BYTES = ROW_BYTES * HEIGHT_ROWS;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic       pixel_value;
        logic       in_range;
        logic       last;
    } t_res_word;

    logic [7:0] frame_bytes [STORE_BYTES];
    t_res_word  expected_words [$];
    int         error_count = 0;

    task automatic push_word(input logic [1:0] kind, input logic [7:0] byte_out,
                             input logic pixel_value, input logic in_range,
                             input logic last);
        t_res_word w;
        w.kind        = kind;
        w.byte_out    = byte_out;
        w.pixel_value = pixel_value;
        w.in_range    = in_range;
        w.last        = last;
        expected_words.push_back(w);
    endtask

    task automatic predict_word(input logic [2:0] mode, input logic [7:0] x,
                                input logic [7:0] y);
        int unsigned idx;
        logic [7:0]  mask;
        logic [7:0]  cur;
        if (mode <= MODE_READ) begin
            if (int'(x) >= WIDTH_PIXELS || int'(y) >= HEIGHT_ROWS) begin
                push_word(KIND_STATUS, '0, 1'b0, 1'b0, 1'b1);
            end else begin
                idx  = int'(y) * ROW_BYTES + int'(x) / 8;
                mask = PIX_MSB_MASK >> x[2:0];
                cur  = frame_bytes[idx];
                case (mode)
                    MODE_CLEAR:  cur = cur & ~mask;
                    MODE_SET:    cur = cur | mask;
                    MODE_TOGGLE: cur = cur ^ mask;
                    default: ;
                endcase
                frame_bytes[idx] = cur;
                push_word(KIND_STATUS, cur, |(cur & mask), 1'b1, 1'b1);
            end
        end else if (mode == MODE_ROW && int'(y) < HEIGHT_ROWS) begin
            push_word(KIND_CMD, CMD_ROW_LO | {4'h0, y[3:0]}, 1'b0, 1'b1, 1'b0);
            push_word(KIND_CMD, CMD_ROW_HI | {4'h0, y[7:4]}, 1'b0, 1'b1, 1'b0);
            push_word(KIND_CMD, CMD_COL_RESET, 1'b0, 1'b1, 1'b0);
            for (int c = 0; c < ROW_BYTES; c++) begin
                push_word(KIND_DATA, frame_bytes[int'(y) * ROW_BYTES + c], 1'b0, 1'b1,
                          c == ROW_BYTES - 1);
            end
        end else begin
            push_word(KIND_STATUS, '0, 1'b0, 1'b0, 1'b1);
        end
    endtask

    task automatic check_word(input t_res_word got);
        t_res_word want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word: kind %0d byte %02h pixel %0b range %0b last %0b",
                     $time, got.kind, got.byte_out, got.pixel_value, got.in_range,
                     got.last);
            error_count++;
        end else begin
            want = expected_words.pop_front();
            if (got.kind != want.kind || got.byte_out != want.byte_out ||
                got.pixel_value != want.pixel_value || got.in_range != want.in_range ||
                got.last != want.last) begin
                $display("%0t: mismatch: expected kind %0d byte %02h pixel %0b range %0b last %0b, got kind %0d byte %02h pixel %0b range %0b last %0b",
                         $time, want.kind, want.byte_out, want.pixel_value, want.in_range,
                         want.last, got.kind, got.byte_out, got.pixel_value, got.in_range,
                         got.last);
                error_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_BYTES; i++) begin
                frame_bytes[i] = '0;
            end
            expected_words.delete();
        end else begin
            // A word accepted at this edge is predicted first, so the queue is in order.
            if (i_pix.valid && i_pix.ready) begin
                predict_word(i_pix.mode, i_pix.x_coord, i_pix.y_coord);
            end
            if (i_res.valid && i_res.ready) begin
                check_word({i_res.kind, i_res.byte_out, i_res.pixel_value, i_res.in_range,
                            i_res.last});
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_words.size();
    end

endmodule

### bench/tb_mono_framebuffer_pixel_scanout_top.sv
// Testbench top for the monochrome frame buffer: drives pixel and row refresh words,
// stalls the result channel at random and gives the verdict.
// Depends on mfb_pkg, mfb_if, the block itself and mfb_scanout_checker.
module tb_mono_framebuffer_pixel_scanout_top
    import mfb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH_PIXELS = 128;
    localparam int HEIGHT_ROWS  = 64;
    localparam int STALL_LIMIT  = 4 * (WIDTH_PIXELS / 8) * HEIGHT_ROWS + 1000;
    localparam int DRAIN_CYCLES = 2 * (4 + WIDTH_PIXELS / 8);
    localparam int RANDOM_CHUNKS = 12;
    localparam int CHUNK_WORDS   = 27;

    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles;
    int   error_total;
    int   pending_words;
    int   hot_rows [4] = '{0, 17, 42, HEIGHT_ROWS - 1};

    mfb_in_if  pix_if ();
    mfb_out_if res_if ();

    mono_framebuffer_pixel_scanout_top #(
        .WIDTH_PIXELS(WIDTH_PIXELS),
        .HEIGHT_ROWS (HEIGHT_ROWS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if.sink),
        .o_res  (res_if.source)
    );

    mfb_scanout_checker #(
        .WIDTH_PIXELS(WIDTH_PIXELS),
        .HEIGHT_ROWS (HEIGHT_ROWS)
    ) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (pix_if),
        .i_res    (res_if),
        .o_errors (error_total),
        .o_pending(pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_mono_framebuffer_pixel_scanout_top: errors");
        $finish;
    end

    task automatic send_word(input logic [2:0] mode, input logic [7:0] x,
                             input logic [7:0] y);
        while ($urandom_range(99) < idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.mode    <= mode;
        pix_if.x_coord <= x;
        pix_if.y_coord <= y;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    initial begin
        int         sel;
        logic [2:0] mode;
        logic [7:0] x;
        logic [7:0] y;

        i_rst_n        <= 1'b0;
        pix_if.valid   <= 1'b0;
        pix_if.mode    <= MODE_CLEAR;
        pix_if.x_coord <= '0;
        pix_if.y_coord <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corners, byte boundaries, both row nibbles, and every rejected case.
        send_word(MODE_READ, 8'd0, 8'd0);
        send_word(MODE_SET, 8'd0, 8'd0);
        send_word(MODE_SET, 8'(WIDTH_PIXELS - 1), 8'(HEIGHT_ROWS - 1));
        send_word(MODE_READ, 8'(WIDTH_PIXELS - 1), 8'(HEIGHT_ROWS - 1));
        send_word(MODE_SET, 8'd7, 8'd0);
        send_word(MODE_SET, 8'd8, 8'd0);
        send_word(MODE_TOGGLE, 8'd1, 8'd0);
        send_word(MODE_ROW, 8'd0, 8'd0);
        send_word(MODE_ROW, 8'd255, 8'(HEIGHT_ROWS - 1));
        send_word(MODE_TOGGLE, 8'(WIDTH_PIXELS - 1), 8'(HEIGHT_ROWS - 1));
        send_word(MODE_CLEAR, 8'd0, 8'd0);
        send_word(MODE_CLEAR, 8'd3, 8'd15);
        send_word(MODE_ROW, 8'd0, 8'd15);
        send_word(MODE_ROW, 8'd0, 8'd16);
        send_word(MODE_SET, 8'(WIDTH_PIXELS), 8'd0);
        send_word(MODE_TOGGLE, 8'd0, 8'(HEIGHT_ROWS));
        send_word(MODE_READ, 8'd255, 8'd255);
        send_word(MODE_CLEAR, 8'd255, 8'd0);
        send_word(MODE_ROW, 8'd0, 8'(HEIGHT_ROWS));
        send_word(MODE_ROW, 8'd0, 8'd255);
        for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) begin
            send_word(3'(m), 8'd5, 8'd5);
        end
        send_word(MODE_ROW, 8'd0, 8'd0);

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            case (chunk % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 58;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 58;
                end
                default: begin
                    idle_pct = 17;
                    stall_pct <= 17;
                end
            endcase
            repeat (CHUNK_WORDS) begin
                sel = $urandom_range(99);
                if ($urandom_range(99) < 70) begin
                    y = 8'(hot_rows[$urandom_range(3)]);
                end else begin
                    y = 8'($urandom_range(HEIGHT_ROWS - 1));
                end
                x = 8'($urandom_range(WIDTH_PIXELS - 1));
                if (sel < 55) begin
                    mode = 3'($urandom_range(MODE_TOGGLE, MODE_CLEAR));
                end else if (sel < 70) begin
                    mode = MODE_READ;
                end else if (sel < 84) begin
                    mode = MODE_ROW;
                end else begin
                    mode = 3'($urandom_range(7));
                    x    = 8'($urandom_range(255));
                    y    = 8'($urandom_range(255));
                end
                send_word(mode, x, y);
            end
        end

        pix_if.valid <= 1'b0;
        stall_pct    <= 0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_total == 0 && pending_words == 0) begin
            $display("tb_mono_framebuffer_pixel_scanout_top: clean");
        end else begin
            $display("tb_mono_framebuffer_pixel_scanout_top: errors");
        end
        $finish;
    end

endmodule
